FILE: rtl/core/gru_pkg.sv
package gru_pkg;

  localparam int HIDDEN_SIZE = 16;
  localparam int INPUT_SIZE  = 16;
  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = 12;

  localparam int ONE       = 1 << FRAC_BITS;
  localparam int MAX_DIM   = (HIDDEN_SIZE > INPUT_SIZE) ? HIDDEN_SIZE : INPUT_SIZE;
  localparam int COL_W     = $clog2(MAX_DIM);
  localparam int HID_AW    = $clog2(HIDDEN_SIZE);
  localparam int IN_AW     = $clog2(INPUT_SIZE);
  localparam int WADDR_W   = COL_W + 3;
  localparam int WDEPTH    = 6 * (2 ** COL_W);
  localparam int NUM_GATES = 3;
  localparam int HV_W      = 14;
  localparam int IDX_W     = 4;
  localparam int PROD_W    = 2 * DATA_WIDTH;
  localparam int SUM_W     = PROD_W + 1;
  localparam int ACC_W     = PROD_W + $clog2(INPUT_SIZE + HIDDEN_SIZE + 1) + 1;
  localparam int PRE_W     = FRAC_BITS + 6;

  localparam logic [1:0] GATE_R = 2'd0;
  localparam logic [1:0] GATE_Z = 2'd1;
  localparam logic [1:0] GATE_U = 2'd2;
  localparam logic SRC_X = 1'b0;
  localparam logic SRC_H = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD_W = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_INPUT  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    TK_NONE, TK_BIAS, TK_MAC, TK_ACT, TK_RH, TK_UPD1, TK_UPD2
  } tok_kind_t;

  typedef enum logic [1:0] {
    S_IDLE, S_RUN, S_DRAIN, S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]              command;
    logic [2:0]              weight_select;
    logic [3:0]              row_index;
    logic [3:0]              col_index;
    logic signed [15:0]      value;
    logic                    last_element;
  } in_req_t;

  typedef struct packed {
    logic signed [HV_W-1:0]  hidden_value;
    logic [IDX_W-1:0]        hidden_index;
    logic                    last_of_run;
  } out_res_t;

  typedef struct packed {
    tok_kind_t                     kind;
    logic [1:0]                    gate;
    logic                          src;
    logic [COL_W-1:0]              col;
    logic signed [DATA_WIDTH-1:0]  operand;
  } tok_t;

  typedef struct packed {
    logic                          w_we;
    logic                          b_we;
    logic                          clr;
    logic [WADDR_W-1:0]            waddr;
    logic [1:0]                    bsel;
    logic signed [DATA_WIDTH-1:0]  data;
  } ld_t;

  function automatic logic signed [HV_W-1:0] sig_fx(input logic signed [PRE_W-1:0] x);
    logic [PRE_W-1:0] a;
    logic [PRE_W-1:0] y;
    a = x[PRE_W-1] ? PRE_W'(-x) : PRE_W'(x);
    if (a >= PRE_W'(5 * ONE)) begin
      y = PRE_W'(ONE);
    end else if (a >= PRE_W'((19 * ONE) / 8)) begin
      y = (a >> 5) + PRE_W'((27 * ONE) / 32);
    end else if (a >= PRE_W'(ONE)) begin
      y = (a >> 3) + PRE_W'((5 * ONE) / 8);
    end else begin
      y = (a >> 2) + PRE_W'(ONE / 2);
    end
    if (x[PRE_W-1]) begin
      y = PRE_W'(ONE) - y;
    end
    return HV_W'(y);
  endfunction

  function automatic logic signed [HV_W-1:0] act_fx(input logic signed [ACC_W-1:0] acc,
                                                   input logic is_tanh);
    logic signed [ACC_W-1:0] pre;
    logic signed [ACC_W-1:0] lim;
    logic signed [PRE_W-1:0] x;
    logic signed [HV_W:0]    s;
    pre = (acc + ACC_W'(ONE / 2)) >>> FRAC_BITS;
    lim = is_tanh ? ACC_W'(8 * ONE) : ACC_W'(16 * ONE);
    if (pre > lim) begin
      pre = lim;
    end else if (pre < -lim) begin
      pre = -lim;
    end
    x = is_tanh ? PRE_W'(pre <<< 1) : PRE_W'(pre);
    s = (HV_W + 1)'(sig_fx(x));
    if (is_tanh) begin
      s = (s <<< 1) - (HV_W + 1)'(ONE);
    end
    return HV_W'(s);
  endfunction

endpackage

FILE: rtl/core/gru_ram.sv
module gru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 96,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/gru_cell.sv
module gru_cell import gru_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tok_t                    tok_i,
  output tok_t                    tok_o,
  input  ld_t                     ld_i,
  output logic signed [HV_W-1:0]  h_o,
  output logic signed [HV_W-1:0]  rh_o
);

  tok_t                          tok_r;
  tok_kind_t                     kind2_r;
  logic [1:0]                    gate2_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [PROD_W-1:0]      prod_nxt;
  logic signed [PROD_W-1:0]      upd_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [DATA_WIDTH-1:0]  bias_r [NUM_GATES];
  logic signed [HV_W-1:0]        r_r, z_r, u_r, h_r, rh_r;
  logic signed [DATA_WIDTH-1:0]  mul_a, mul_b;
  logic [DATA_WIDTH-1:0]         w_rd;
  logic signed [SUM_W-1:0]       upd_sum;

  gru_ram #(.WIDTH(DATA_WIDTH), .DEPTH(WDEPTH)) u_wram (
    .clk   (clk),
    .we    (ld_i.w_we),
    .waddr (ld_i.waddr),
    .wdata (ld_i.data),
    .raddr ({tok_i.gate, tok_i.src, tok_i.col}),
    .rdata (w_rd)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (tok_r.kind)
      TK_MAC: begin
        mul_a = signed'(w_rd);
        mul_b = tok_r.operand;
      end
      TK_RH: begin
        mul_a = DATA_WIDTH'(r_r);
        mul_b = DATA_WIDTH'(h_r);
      end
      TK_UPD1: begin
        mul_a = DATA_WIDTH'(ONE) - DATA_WIDTH'(z_r);
        mul_b = DATA_WIDTH'(h_r);
      end
      TK_UPD2: begin
        mul_a = DATA_WIDTH'(z_r);
        mul_b = DATA_WIDTH'(u_r);
      end
      default: begin
      end
    endcase
    prod_nxt = mul_a * mul_b;
    upd_sum  = SUM_W'(upd_r) + SUM_W'(prod_r) + SUM_W'(ONE / 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      kind2_r <= TK_NONE;
      h_r     <= '0;
      for (int g = 0; g < NUM_GATES; g++) begin
        bias_r[g] <= '0;
      end
    end else begin
      tok_r   <= tok_i;
      kind2_r <= tok_r.kind;
      if (ld_i.b_we) begin
        bias_r[ld_i.bsel] <= ld_i.data;
      end
      if (ld_i.clr) begin
        h_r <= '0;
      end else if (kind2_r == TK_UPD2) begin
        h_r <= HV_W'(upd_sum >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    gate2_r <= tok_r.gate;
    prod_r  <= prod_nxt;
    case (kind2_r)
      TK_BIAS: acc_r <= ACC_W'(bias_r[gate2_r]) <<< FRAC_BITS;
      TK_MAC:  acc_r <= acc_r + ACC_W'(prod_r);
      TK_ACT: begin
        case (gate2_r)
          GATE_R:  r_r <= act_fx(acc_r, 1'b0);
          GATE_Z:  z_r <= act_fx(acc_r, 1'b0);
          default: u_r <= act_fx(acc_r, 1'b1);
        endcase
      end
      TK_RH:   rh_r  <= HV_W'((prod_r + PROD_W'(ONE / 2)) >>> FRAC_BITS);
      TK_UPD1: upd_r <= prod_r;
      default: begin
      end
    endcase
  end

  assign tok_o = tok_r;
  assign h_o   = h_r;
  assign rh_o  = rh_r;

endmodule

FILE: rtl/core/gru_cell_forward_top.sv
// GRU cell forward step in Q4.12. Weight, bias, clear and input-element requests are taken
// only while idle. The request carrying the last input element starts a step: a token stream of
// 3*(INPUT_SIZE+HIDDEN_SIZE+2)+3 slots (105) runs down a chain of HIDDEN_SIZE cells, one per
// hidden row, each with its own weight RAM and one multiplier, then a drain state empties
// the chain, then the HIDDEN_SIZE new hidden elements leave one per cycle in index order
// while out_ready stays high. No request is taken during a step, but one is taken while the
// last result still waits at the output.
module gru_cell_forward_top import gru_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_data
);

  localparam int PASS_LEN  = INPUT_SIZE + HIDDEN_SIZE + 2;
  localparam int RH_SLOT   = 2 * PASS_LEN;
  localparam int U_BASE    = RH_SLOT + 1;
  localparam int UPD1_SLOT = U_BASE + PASS_LEN;
  localparam int LAST_SLOT = UPD1_SLOT + 1;
  localparam int SLOT_W    = $clog2(LAST_SLOT + 1);
  localparam int DRAIN_LEN = HIDDEN_SIZE + 3;
  localparam int DR_W      = $clog2(DRAIN_LEN + 1);

  state_t                        state_r, state_nxt;
  logic [SLOT_W-1:0]             slot_r, slot_nxt;
  logic [DR_W-1:0]               drain_r, drain_nxt;
  logic [HID_AW-1:0]             emit_r, emit_nxt;
  logic signed [DATA_WIDTH-1:0]  xbuf_r [INPUT_SIZE];
  tok_t                          head_r, head_nxt;
  tok_t                          tok_w [HIDDEN_SIZE];
  ld_t                           ld_w [HIDDEN_SIZE];
  logic signed [HV_W-1:0]        h_w  [HIDDEN_SIZE];
  logic signed [HV_W-1:0]        rh_w [HIDDEN_SIZE];
  out_res_t                      out_r, out_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          in_acc, start, w_ok;
  logic [SLOT_W-1:0]             base, off;

  assign in_acc = in_valid && in_ready;
  assign start  = in_acc && (in_data.command == CMD_INPUT) && in_data.last_element;
  assign w_ok   = (in_data.command == CMD_LOAD_W) && (in_data.weight_select < 3'd6) &&
                  (in_data.weight_select[0] ? (in_data.col_index < HIDDEN_SIZE)
                                            : (in_data.col_index < INPUT_SIZE));

  for (genvar j = 0; j < HIDDEN_SIZE; j++) begin : g_cell
    always_comb begin
      ld_w[j].w_we  = in_acc && w_ok && (in_data.row_index == j);
      ld_w[j].b_we  = in_acc && (in_data.command == CMD_LOAD_B) &&
                      (in_data.weight_select < 3'd3) && (in_data.row_index == j);
      ld_w[j].clr   = in_acc && (in_data.command == CMD_CLEAR);
      ld_w[j].waddr = {in_data.weight_select[2:1], in_data.weight_select[0],
                       COL_W'(in_data.col_index)};
      ld_w[j].bsel  = in_data.weight_select[1:0];
      ld_w[j].data  = DATA_WIDTH'(in_data.value);
    end

    gru_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i ((j == 0) ? head_r : tok_w[(j == 0) ? 0 : j - 1]),
      .tok_o (tok_w[j]),
      .ld_i  (ld_w[j]),
      .h_o   (h_w[j]),
      .rh_o  (rh_w[j])
    );
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.command == CMD_INPUT) && (in_data.col_index < INPUT_SIZE)) begin
      xbuf_r[IN_AW'(in_data.col_index)] <= DATA_WIDTH'(in_data.value);
    end
  end

  // token issue
  always_comb begin
    head_nxt = '0;
    base     = '0;
    off      = '0;
    if (state_r == S_RUN) begin
      if (slot_r == SLOT_W'(RH_SLOT)) begin
        head_nxt.kind = TK_RH;
      end else if (slot_r == SLOT_W'(UPD1_SLOT)) begin
        head_nxt.kind = TK_UPD1;
      end else if (slot_r == SLOT_W'(LAST_SLOT)) begin
        head_nxt.kind = TK_UPD2;
      end else begin
        if (slot_r < SLOT_W'(PASS_LEN)) begin
          head_nxt.gate = GATE_R;
          base          = '0;
        end else if (slot_r < SLOT_W'(2 * PASS_LEN)) begin
          head_nxt.gate = GATE_Z;
          base          = SLOT_W'(PASS_LEN);
        end else begin
          head_nxt.gate = GATE_U;
          base          = SLOT_W'(U_BASE);
        end
        off = slot_r - base;
        if (off == '0) begin
          head_nxt.kind = TK_BIAS;
        end else if (off <= SLOT_W'(INPUT_SIZE)) begin
          head_nxt.kind    = TK_MAC;
          head_nxt.src     = SRC_X;
          head_nxt.col     = COL_W'(off - SLOT_W'(1));
          head_nxt.operand = xbuf_r[IN_AW'(off - SLOT_W'(1))];
        end else if (off <= SLOT_W'(INPUT_SIZE + HIDDEN_SIZE)) begin
          head_nxt.kind    = TK_MAC;
          head_nxt.src     = SRC_H;
          head_nxt.col     = COL_W'(off - SLOT_W'(INPUT_SIZE + 1));
          head_nxt.operand = (head_nxt.gate == GATE_U)
                             ? DATA_WIDTH'(rh_w[HID_AW'(off - SLOT_W'(INPUT_SIZE + 1))])
                             : DATA_WIDTH'(h_w[HID_AW'(off - SLOT_W'(INPUT_SIZE + 1))]);
        end else begin
          head_nxt.kind = TK_ACT;
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    drain_nxt     = drain_r;
    emit_nxt      = emit_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RUN;
          slot_nxt  = '0;
        end
      end
      S_RUN: begin
        slot_nxt = slot_r + SLOT_W'(1);
        if (slot_r == SLOT_W'(LAST_SLOT)) begin
          state_nxt = S_DRAIN;
          drain_nxt = '0;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r + DR_W'(1);
        if (drain_r == DR_W'(DRAIN_LEN - 1)) begin
          state_nxt = S_EMIT;
          emit_nxt  = '0;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_nxt.hidden_value = h_w[emit_r];
          out_nxt.hidden_index = IDX_W'(emit_r);
          out_nxt.last_of_run  = (emit_r == HID_AW'(HIDDEN_SIZE - 1));
          emit_nxt             = emit_r + HID_AW'(1);
          if (emit_r == HID_AW'(HIDDEN_SIZE - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    drain_r <= drain_nxt;
    emit_r  <= emit_nxt;
    out_r   <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/gru_checker.sv
module gru_checker import gru_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input in_req_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input out_res_t out_data
);

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_run |-> out_data.hidden_index == IDX_W'(HIDDEN_SIZE - 1))
    else $error("last element not at final hidden index");

  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_run |-> !in_ready)
    else $error("request taken in the middle of a result run");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hidden_value >= -ONE) && (out_data.hidden_value <= ONE))
    else $error("hidden value out of range");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_run |=>
      out_valid && (out_data.hidden_index == IDX_W'($past(out_data.hidden_index) + 1'b1)))
    else $error("hidden elements not back to back in order");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind gru_cell_forward_top gru_checker u_chk (.*);

FILE: test/gru_cell_forward_checker.sv
module gru_cell_forward_checker import gru_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_res_t out_data,
  output int       fails,
  output int       pending,
  output int       checked,
  output int       steps
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;
  localparam longint ACC_MAX = (longint'(1) <<< 62) - 1;
  localparam longint H_MAX = (longint'(1) << (DATA_WIDTH - 1)) - 1;

  longint w_in [3][HIDDEN_SIZE][INPUT_SIZE];
  longint w_rec [3][HIDDEN_SIZE][HIDDEN_SIZE];
  longint bias [3][HIDDEN_SIZE];
  longint hid [HIDDEN_SIZE];
  longint xbuf [INPUT_SIZE];
  out_res_t hidden_expect[$];

  function automatic longint round_q(longint x);
    return (x + ONE_Q / 2) >>> FRAC_BITS;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > ACC_MAX) s = ACC_MAX;
    if (s < -ACC_MAX) s = -ACC_MAX;
    return s;
  endfunction

  function automatic longint sigmoid_q(longint xi);
    longint x, a, y;
    x = xi;
    if (x > 16 * ONE_Q) x = 16 * ONE_Q;
    if (x < -16 * ONE_Q) x = -16 * ONE_Q;
    a = (x < 0) ? -x : x;
    if (a >= 5 * ONE_Q) y = ONE_Q;
    else if (a >= (19 * ONE_Q) / 8) y = a / 32 + (27 * ONE_Q) / 32;
    else if (a >= ONE_Q) y = a / 8 + (5 * ONE_Q) / 8;
    else y = a / 4 + ONE_Q / 2;
    return (x < 0) ? ONE_Q - y : y;
  endfunction

  function automatic longint tanh_q(longint xi);
    longint x;
    x = xi;
    if (x > 16 * ONE_Q) x = 16 * ONE_Q;
    if (x < -16 * ONE_Q) x = -16 * ONE_Q;
    return 2 * sigmoid_q(2 * x) - ONE_Q;
  endfunction

  function automatic longint gate_preact(int g, int j, longint vec [HIDDEN_SIZE]);
    longint acc;
    acc = bias[g][j] * ONE_Q;
    for (int c = 0; c < INPUT_SIZE; c++) acc = sat_add(acc, w_in[g][j][c] * xbuf[c]);
    for (int c = 0; c < HIDDEN_SIZE; c++) acc = sat_add(acc, w_rec[g][j][c] * vec[c]);
    return round_q(acc);
  endfunction

  task automatic cell_step();
    longint rg [HIDDEN_SIZE];
    longint zg [HIDDEN_SIZE];
    longint ug [HIDDEN_SIZE];
    longint rh [HIDDEN_SIZE];
    longint hn;
    out_res_t e;
    for (int j = 0; j < HIDDEN_SIZE; j++) begin
      rg[j] = sigmoid_q(gate_preact(0, j, hid));
      zg[j] = sigmoid_q(gate_preact(1, j, hid));
    end
    for (int j = 0; j < HIDDEN_SIZE; j++) rh[j] = round_q(rg[j] * hid[j]);
    for (int j = 0; j < HIDDEN_SIZE; j++) ug[j] = tanh_q(gate_preact(2, j, rh));
    for (int j = 0; j < HIDDEN_SIZE; j++) begin
      hn = round_q((ONE_Q - zg[j]) * hid[j] + zg[j] * ug[j]);
      if (hn > H_MAX) hn = H_MAX;
      if (hn < -H_MAX - 1) hn = -H_MAX - 1;
      hid[j] = hn;
      e.hidden_value = hn[HV_W-1:0];
      e.hidden_index = IDX_W'(j);
      e.last_of_run = (j == HIDDEN_SIZE - 1);
      hidden_expect.push_back(e);
    end
    steps++;
  endtask

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    checked = 0;
    steps = 0;
    pending = 0;
    foreach (w_in[g, j, c]) w_in[g][j][c] = 0;
    foreach (w_rec[g, j, c]) w_rec[g][j][c] = 0;
    foreach (bias[g, j]) bias[g][j] = 0;
    foreach (hid[j]) hid[j] = 0;
    foreach (xbuf[c]) xbuf[c] = 0;
  end

  always @(posedge clk) begin
    in_req_t r;
    out_res_t e;
    longint v;
    if (rst_n && out_valid && out_ready) begin
      if (hidden_expect.size() == 0) begin
        report("unexpected result, index", out_data.hidden_index, -1);
      end else begin
        e = hidden_expect.pop_front();
        checked++;
        if (out_data.hidden_value !== e.hidden_value)
          report($sformatf("hidden_value[%0d]", e.hidden_index),
                 out_data.hidden_value, e.hidden_value);
        if (out_data.hidden_index !== e.hidden_index)
          report("hidden_index", out_data.hidden_index, e.hidden_index);
        if (out_data.last_of_run !== e.last_of_run)
          report($sformatf("last_of_run[%0d]", e.hidden_index),
                 out_data.last_of_run, e.last_of_run);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      r = in_data;
      v = longint'(r.value);
      case (r.command)
        CMD_LOAD_W: begin
          if (r.weight_select < 6) begin
            if (!r.weight_select[0]) w_in[r.weight_select >> 1][r.row_index][r.col_index] = v;
            else w_rec[r.weight_select >> 1][r.row_index][r.col_index] = v;
          end
        end
        CMD_LOAD_B: begin
          if (r.weight_select < 3) bias[r.weight_select][r.row_index] = v;
        end
        CMD_CLEAR: begin
          foreach (hid[j]) hid[j] = 0;
        end
        default: begin
          xbuf[r.col_index] = v;
          if (r.last_element) cell_step();
        end
      endcase
    end
    pending = hidden_expect.size();
  end

endmodule

FILE: test/tb_gru_cell_forward_top.sv
module tb_gru_cell_forward_top;
  import gru_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_data;
  int       fails, pending, checked, steps;
  int       sent = 0;
  int       quiet = 0;
  int       taken = 0;
  bit       no_idle = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gru_cell_forward_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  gru_cell_forward_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fails(fails), .pending(pending), .checked(checked), .steps(steps)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("tb_gru_cell_forward_top: FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (taken == 40) gap = 600;
      @(negedge clk);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  function automatic logic signed [15:0] pick_value();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 4095)) - 2048);
  endfunction

  task automatic send(in_req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = r;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic make_send(cmd_e_t cmd, int sel, int row, int col,
                           logic signed [15:0] val, bit last);
    in_req_t r;
    r.command = cmd;
    r.weight_select = 3'(sel);
    r.row_index = 4'(row);
    r.col_index = 4'(col);
    r.value = val;
    r.last_element = last;
    send(r);
  endtask

  task automatic input_vector(bit extreme);
    int order [INPUT_SIZE];
    int k, t;
    logic signed [15:0] v;
    foreach (order[i]) order[i] = i;
    for (int i = INPUT_SIZE - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = order[i];
      order[i] = order[k];
      order[k] = t;
    end
    foreach (order[i]) begin
      if (extreme) v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      else v = 16'(int'($urandom_range(0, 8191)) - 4096);
      if ($urandom_range(0, 9) == 0) v = 16'($urandom);
      make_send(CMD_INPUT, $urandom_range(0, 7), $urandom_range(0, 15), order[i], v,
                i == INPUT_SIZE - 1);
    end
  endtask

  initial begin
    int pick;
    in_req_t r;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    no_idle = 1'b1;
    for (int s = 0; s < 6; s++)
      for (int j = 0; j < HIDDEN_SIZE; j++)
        for (int c = 0; c < HIDDEN_SIZE; c++)
          make_send(CMD_LOAD_W, s, j, c, pick_value(), 1'b0);
    for (int g = 0; g < 3; g++)
      for (int j = 0; j < HIDDEN_SIZE; j++)
        make_send(CMD_LOAD_B, g, j, 0, pick_value(), 1'b0);
    no_idle = 1'b0;

    // zero state step, extremes, ignored selects and flags
    input_vector(1'b0);
    make_send(CMD_LOAD_W, 0, 15, 15, 16'sh7fff, 1'b1);
    make_send(CMD_LOAD_W, 5, 0, 0, 16'sh8000, 1'b0);
    make_send(CMD_LOAD_W, 6, 3, 3, 16'sh1234, 1'b0);
    make_send(CMD_LOAD_W, 7, 4, 4, 16'shedcb, 1'b1);
    make_send(CMD_LOAD_B, 2, 15, 9, 16'sh7fff, 1'b0);
    make_send(CMD_LOAD_B, 0, 0, 0, 16'sh8000, 1'b1);
    make_send(CMD_LOAD_B, 3, 1, 1, 16'sh4000, 1'b0);
    make_send(CMD_LOAD_B, 7, 2, 2, 16'shc000, 1'b0);
    make_send(CMD_CLEAR, 7, 15, 15, 16'sh7fff, 1'b1);
    make_send(CMD_INPUT, 0, 0, 0, 16'sh7fff, 1'b0);
    make_send(CMD_INPUT, 0, 0, 15, 16'sh8000, 1'b1);
    make_send(CMD_INPUT, 5, 15, 7, 16'sh0000, 1'b1);
    make_send(CMD_CLEAR, 0, 0, 0, 16'sh0000, 1'b0);
    input_vector(1'b1);
    input_vector(1'b1);

    sent = 0;
    while (sent < 360) begin
      if (sent > 180 && sent < 200) begin
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        no_idle = ($urandom_range(0, 3) == 0);
        input_vector($urandom_range(0, 9) == 0);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 6))
          make_send(CMD_LOAD_W, $urandom_range(0, 5), $urandom_range(0, 15),
                    $urandom_range(0, 15), pick_value(), $urandom_range(0, 1));
      end else if (pick < 83) begin
        make_send(CMD_LOAD_B, $urandom_range(0, 2), $urandom_range(0, 15),
                  $urandom_range(0, 15), pick_value(), $urandom_range(0, 1));
      end else if (pick < 88) begin
        make_send(CMD_CLEAR, $urandom_range(0, 7), $urandom_range(0, 15),
                  $urandom_range(0, 15), 16'($urandom), $urandom_range(0, 1));
      end else if (pick < 93) begin
        make_send(CMD_INPUT, $urandom_range(0, 7), $urandom_range(0, 15),
                  $urandom_range(0, 15), pick_value(), $urandom_range(0, 1));
      end else begin
        r = in_req_t'($urandom);
        send(r);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk);
    $display("covered weight/bias loads, clears, ignored selects and %0d cell steps", steps);
    $display("%0d hidden elements checked, %0d mismatches", checked, fails);
    if (fails == 0) begin
      $display("tb_gru_cell_forward_top: PASS");
    end else begin
      $display("tb_gru_cell_forward_top: FAIL");
    end
    $finish;
  end

endmodule
